>>> rtl/core/swm_pkg.sv
// Shared constants for the sliding window minimum block.
// Used by the top level and the deque controller; no dependencies.
`timescale 1ns / 1ps

package swm_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int CFG_W          = 11;
  localparam int WINDOW_MAX_DEF = 1024;
  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = CFG_W'(1);

endpackage

>>> rtl/core/sliding_window_minimum.sv
// A result is registered at the end of its word's work pass, after each head candidate
// is evicted and each tail candidate discarded, once the output register is free.
// A new word is accepted only after the last one has been appended; pops run one per cycle,
// set by the loop around the candidate memory read ports, and average at most one per word.
// Reset is synchronous: the deque is empty and the window length is one; the
// candidate memory is not cleared, since only written entries are ever read.
`timescale 1ns / 1ps

module sliding_window_minimum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,   // sample
  input  logic                         s_axis_tuser,   // start_req
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [swm_pkg::SAMPLE_W-1:0] m_axis_tdata    // window_min
);

  import swm_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW_MAX);
  localparam int POS_W  = PTR_W + 1;
  localparam int DATA_W = SAMPLE_W + POS_W;

  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [PTR_W-1:0]  rd_addr_a;
  logic [DATA_W-1:0] rd_data_a;
  logic [PTR_W-1:0]  rd_addr_b;
  logic [DATA_W-1:0] rd_data_b;

  swm_deque_ctrl #(
    .WINDOW_MAX (WINDOW_MAX),
    .PTR_W      (PTR_W),
    .POS_W      (POS_W),
    .DATA_W     (DATA_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_addr_a     (rd_addr_a),
    .rd_data_a     (rd_data_a),
    .rd_addr_b     (rd_addr_b),
    .rd_data_b     (rd_data_b)
  );

  swm_cand_ram #(
    .DEPTH  (WINDOW_MAX),
    .ADDR_W (PTR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

`ifndef SYNTHESIS
  // The sequencer works on one word at a time, so an accept closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word was still in work");

  // A new result is only produced at the end of a work pass.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a work pass");
`endif

endmodule

>>> rtl/core/swm_cand_ram.sv
// Candidate store: one write port and two registered read ports.
// Generic memory, no package dependencies.
`timescale 1ns / 1ps

module swm_cand_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 43
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  output logic [DATA_W-1:0] rd_data_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> rtl/core/swm_deque_ctrl.sv
// Deque sequencer: evicts old head candidates, trims the tail, appends the sample.
// Depends on swm_pkg and drives the ports of swm_cand_ram.
`timescale 1ns / 1ps

module swm_deque_ctrl #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
  parameter int PTR_W      = $clog2(WINDOW_MAX),
  parameter int POS_W      = PTR_W + 1,
  parameter int DATA_W     = swm_pkg::SAMPLE_W + POS_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swm_pkg::SAMPLE_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [swm_pkg::SAMPLE_W-1:0]  m_axis_tdata,
  output logic                          wr_en,
  output logic [PTR_W-1:0]              wr_addr,
  output logic [DATA_W-1:0]             wr_data,
  output logic [PTR_W-1:0]              rd_addr_a,
  input  logic [DATA_W-1:0]             rd_data_a,
  output logic [PTR_W-1:0]              rd_addr_b,
  input  logic [DATA_W-1:0]             rd_data_b
);

  import swm_pkg::*;

  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int CMP_W   = (POS_W > CFG_W) ? POS_W : CFG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic                state, state_next;
  logic [PTR_W-1:0]    head, head_next;
  logic [PTR_W-1:0]    tail, tail_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [POS_W-1:0]    spos, spos_next;
  logic [POS_W-1:0]    pos_cur, pos_cur_next;
  logic [SAMPLE_W-1:0] x_reg, x_reg_next;
  logic [CFG_W-1:0]    win_len;
  logic                out_valid, out_valid_next;
  logic [SAMPLE_W-1:0] out_data, out_data_next;

  logic [POS_W:0]      age_diff;
  logic [POS_W:0]      age_wrap;
  logic [POS_W-1:0]    age;
  logic [CMP_W-1:0]    win_eff;
  logic [CMP_W-1:0]    win_ext;
  logic                evict;
  logic                trim;
  logic                out_free;
  logic                accept;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(WINDOW_MAX - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(WINDOW_MAX - 1) : p - PTR_W'(1);
  endfunction

  assign win_ext = CMP_W'(win_len);

  always_comb begin
    if (win_len == '0) begin
      win_eff = CMP_W'(1);
    end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
      win_eff = CMP_W'(WINDOW_MAX);
    end else begin
      win_eff = win_ext;
    end
  end

  // Distance from the head candidate to the current position, modulo the position range.
  assign age_diff = {1'b0, pos_cur} - {1'b0, rd_data_a[DATA_W-1 -: POS_W]};
  assign age_wrap = age_diff + (POS_W+1)'(POS_MOD);
  assign age      = age_diff[POS_W] ? age_wrap[POS_W-1:0] : age_diff[POS_W-1:0];

  assign evict    = (count != '0) && (CMP_W'(age) >= win_eff);
  assign trim     = (count != '0) &&
                    !($signed(rd_data_b[SAMPLE_W-1:0]) < $signed(x_reg));
  assign out_free = !out_valid || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    spos_next      = spos;
    pos_cur_next   = pos_cur;
    x_reg_next     = x_reg;
    out_valid_next = out_valid && !m_axis_tready;
    out_data_next  = out_data;
    wr_en          = 1'b0;
    wr_addr        = tail;
    wr_data        = {pos_cur, x_reg};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          x_reg_next = s_axis_tdata;
          state_next = ST_WORK;
          if (s_axis_tuser) begin
            head_next    = '0;
            tail_next    = '0;
            count_next   = '0;
            pos_cur_next = '0;
          end else begin
            pos_cur_next = spos;
          end
        end
      end
      ST_WORK: begin
        if (evict) begin
          head_next  = ptr_inc(head);
          count_next = count - CNT_W'(1);
        end else if (trim) begin
          tail_next  = ptr_dec(tail);
          count_next = count - CNT_W'(1);
        end else if (out_free) begin
          wr_en          = 1'b1;
          tail_next      = ptr_inc(tail);
          count_next     = count + CNT_W'(1);
          spos_next      = (pos_cur == POS_W'(POS_MOD - 1)) ? '0 : pos_cur + POS_W'(1);
          out_valid_next = 1'b1;
          out_data_next  = (count == '0) ? x_reg : rd_data_a[SAMPLE_W-1:0];
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_a = head_next;
  assign rd_addr_b = ptr_dec(tail_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      spos      <= '0;
      out_valid <= 1'b0;
      win_len   <= WINDOW_LEN_RST;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      spos      <= spos_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        win_len <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_cur  <= pos_cur_next;
    x_reg    <= x_reg_next;
    out_data <= out_data_next;
  end

endmodule
